// ===== design/double_to_custom_float_unit_defines.svh =====
// ----------------------------------------------------------------------------
// double_to_custom_float_unit_defines
// Assertion macros used by the converter top level.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_TO_CUSTOM_FLOAT_UNIT_DEFINES_SVH
`define DOUBLE_TO_CUSTOM_FLOAT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Clocked check, masked while reset is high.
`define DCF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define DCF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DCF_ASSERT(lbl, clk, rst, prop, msg)
`define DCF_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

// ===== design/dcf_pkg.sv =====
// ----------------------------------------------------------------------------
// dcf_pkg
// Types and constants for the double to custom float converter.
// ----------------------------------------------------------------------------
package dcf_pkg;

  localparam int DBL_FRAC_W   = 52;
  localparam int DBL_EXP_W    = 11;
  localparam int DBL_SIGN_POS = 63;
  localparam int DBL_BIAS     = 1023;
  localparam int WORD_W       = 64;
  localparam int EXP_FIELD_W  = 31;  // widest target exponent
  localparam int BE_W         = 32;  // signed rebiased exponent
  localparam int FW_W         = 6;   // target fraction width 0..62
  localparam int TB_W         = 7;
  localparam int EB_W         = 5;
  localparam int CFG_DATA_W   = 7;
  localparam int CFG_IDX_W    = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_BITS = 1'b0,
    REG_EXP_BITS   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [TB_W-1:0] total_bits;
    logic [EB_W-1:0] exp_bits;
  } cfg_t;

  // decode stage result
  typedef struct packed {
    logic                   sign;
    logic                   bad;
    logic                   exp_zero;
    logic                   exp_max;
    logic                   frac_nz;
    logic [DBL_FRAC_W-1:0]  frac;
    logic signed [BE_W-1:0] be;
    logic [FW_W-1:0]        fw;
  } dec_t;

  // align stage result
  typedef struct packed {
    logic                   sign;
    logic                   bad;
    logic [EXP_FIELD_W-1:0] exp_field;
    logic [WORD_W-1:0]      frac_field;
    logic [FW_W-1:0]        fw;
  } aln_t;

endpackage

// ===== design/dcf_decode.sv =====
// ----------------------------------------------------------------------------
// dcf_decode
// Stage 1: splits the double, classifies it and rebiases the exponent.
// ----------------------------------------------------------------------------
module dcf_decode (
  input  logic                          clk,
  input  logic                          rst,
  input  dcf_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dcf_pkg::WORD_W-1:0]    double_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dcf_pkg::dec_t                 out_data
);
  import dcf_pkg::*;

  logic                    valid;
  dec_t                    data;
  dec_t                    data_next;
  logic [DBL_EXP_W-1:0]    dexp;
  logic [EXP_FIELD_W-1:0]  bias;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    dexp = double_bits[DBL_FRAC_W +: DBL_EXP_W];
    bias = EXP_FIELD_W'((32'd1 << EB_W'(cfg.exp_bits - EB_W'(1))) - 32'd1);
    data_next.sign     = double_bits[DBL_SIGN_POS];
    data_next.bad      = (cfg.exp_bits == '0) ||
                         (cfg.total_bits <= {2'b00, cfg.exp_bits}) ||
                         (cfg.total_bits > TB_W'(WORD_W));
    data_next.exp_zero = (dexp == '0);
    data_next.exp_max  = (dexp == '1);
    data_next.frac     = double_bits[DBL_FRAC_W-1:0];
    data_next.frac_nz  = (double_bits[DBL_FRAC_W-1:0] != '0);
    data_next.be       = signed'(BE_W'({21'b0, dexp}) + BE_W'({1'b0, bias})
                                 - BE_W'(DBL_BIAS));
    data_next.fw       = FW_W'(cfg.total_bits - {2'b00, cfg.exp_bits} - TB_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== design/dcf_align.sv =====
// ----------------------------------------------------------------------------
// dcf_align
// Stage 2: range checks on the exponent and fraction alignment.
// ----------------------------------------------------------------------------
module dcf_align (
  input  logic            clk,
  input  logic            rst,
  input  dcf_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  dcf_pkg::dec_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dcf_pkg::aln_t   out_data
);
  import dcf_pkg::*;

  logic                   valid;
  aln_t                   data;
  aln_t                   data_next;
  logic [EXP_FIELD_W-1:0] emax;
  logic [WORD_W-1:0]      frac_ext;
  logic                   ovf;
  logic                   unf;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    emax     = EXP_FIELD_W'((32'd1 << cfg.exp_bits) - 32'd1);
    frac_ext = {12'b0, in_data.frac};
    ovf      = (in_data.be >= signed'({1'b0, emax}));
    unf      = (in_data.be <= BE_W'(0));

    data_next.sign       = in_data.sign;
    data_next.bad        = in_data.bad;
    data_next.fw         = in_data.fw;
    data_next.exp_field  = '0;
    data_next.frac_field = '0;

    if (in_data.exp_zero) begin
      // zero or subnormal: signed zero
    end else if (in_data.exp_max) begin
      data_next.exp_field = emax;
      if (in_data.frac_nz && (in_data.fw != '0)) begin
        data_next.frac_field = WORD_W'(1) << FW_W'(in_data.fw - FW_W'(1));
      end
    end else if (ovf) begin
      data_next.exp_field = emax;
    end else if (unf) begin
      // flush to signed zero
    end else begin
      data_next.exp_field = in_data.be[EXP_FIELD_W-1:0];
      if (in_data.fw < FW_W'(DBL_FRAC_W)) begin
        data_next.frac_field = frac_ext >> FW_W'(FW_W'(DBL_FRAC_W) - in_data.fw);
      end else begin
        data_next.frac_field = frac_ext << FW_W'(in_data.fw - FW_W'(DBL_FRAC_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== design/dcf_pack.sv =====
// ----------------------------------------------------------------------------
// dcf_pack
// Stage 3: places sign, exponent and fraction into the output word.
// ----------------------------------------------------------------------------
module dcf_pack (
  input  logic                        clk,
  input  logic                        rst,
  input  dcf_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dcf_pkg::aln_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dcf_pkg::WORD_W-1:0]  converted_bits,
  output logic                        bad_format
);
  import dcf_pkg::*;

  logic              valid;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] word_next;
  logic              bad;
  logic [FW_W-1:0]   sign_pos;

  assign in_ready       = !valid || out_ready;
  assign out_valid      = valid;
  assign converted_bits = word;
  assign bad_format     = bad;

  always_comb begin
    sign_pos = FW_W'(cfg.total_bits - TB_W'(1));
    if (in_data.bad) begin
      word_next = '0;
    end else begin
      word_next = ({63'b0, in_data.sign} << sign_pos) |
                  ({33'b0, in_data.exp_field} << in_data.fw) |
                  in_data.frac_field;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= word_next;
      bad  <= in_data.bad;
    end
  end

endmodule

// ===== design/double_to_custom_float_unit.sv =====
// ----------------------------------------------------------------------------
// double_to_custom_float_unit
// Double to custom-width float converter, three-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one IEEE-754 double request per cycle while in_ready is high and
// returns it in a float format of total_bits width with exp_bits exponent
// bits, right-aligned in 64 bits (sign, exponent, fraction; unused upper
// bits zero). A request passes through three register stages (decode,
// align, pack), each of which holds its item while the stage after it is
// stalled. The fraction is truncated, never rounded. Zero and double
// subnormals give signed zero, out-of-range exponents give signed infinity
// or signed zero, NaN sets only the top fraction bit. A format with
// exp_bits of zero, total_bits not above exp_bits, or total_bits above 64
// returns zero with bad_format set. Write total_bits (index 0) and exp_bits
// (index 1) only while the pipeline is empty.
// ----------------------------------------------------------------------------
`include "double_to_custom_float_unit_defines.svh"

module double_to_custom_float_unit (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            wr_en,
  input  logic [dcf_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [dcf_pkg::CFG_DATA_W-1:0]  wr_data,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dcf_pkg::WORD_W-1:0]      double_bits,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dcf_pkg::WORD_W-1:0]      converted_bits,
  output logic                            bad_format
);
  import dcf_pkg::*;

  // format registers
  logic [TB_W-1:0] total_bits;
  logic [EB_W-1:0] exp_bits;
  cfg_t            cfg;

  // stage links
  logic dec_valid;
  logic dec_ready;
  dec_t dec_data;
  logic aln_valid;
  logic aln_ready;
  aln_t aln_data;

  assign cfg.total_bits = total_bits;
  assign cfg.exp_bits   = exp_bits;

  // Write port: registered writes, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_bits <= TB_W'(32);
      exp_bits   <= EB_W'(8);
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_TOTAL_BITS: total_bits <= wr_data[TB_W-1:0];
        REG_EXP_BITS:   exp_bits   <= wr_data[EB_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: field split, class flags, rebias
  dcf_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .double_bits (double_bits),
    .out_valid   (dec_valid),
    .out_ready   (dec_ready),
    .out_data    (dec_data)
  );

  // Stage 2: overflow/underflow decision, fraction shift
  dcf_align u_align (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (aln_valid),
    .out_ready (aln_ready),
    .out_data  (aln_data)
  );

  // Stage 3: word assembly; its register is the output register
  dcf_pack u_pack (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (aln_valid),
    .in_ready       (aln_ready),
    .in_data        (aln_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .converted_bits (converted_bits),
    .bad_format     (bad_format)
  );

  // Checks
  `DCF_ASSERT(a_bad_is_zero, clk, rst, (out_valid && bad_format) |-> (converted_bits == '0), "bad format result not zero")
  `DCF_ASSERT(a_ready_follows_out, clk, rst, out_ready |-> in_ready, "input stalled while output drains")
  `DCF_ASSERT(a_stall_means_full, clk, rst, !in_ready |-> (dec_valid && aln_valid && out_valid && !out_ready), "input stalled with a free stage")
  `DCF_ASSERT_NR(a_reset_empties, clk, rst |=> !out_valid, "result valid right after reset")

endmodule
